### hw/rtl/etl_pkg.sv
// Shared types and constants for the expression token lexer.
// No dependencies; imported by every lexer module.
package etl_pkg;

  localparam int unsigned POS_WIDTH_DEF = 16;
  localparam int unsigned TOKQ_DEPTH    = 4;

  // Character codes
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_EQUALS     = 8'h3D;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

  typedef enum logic [2:0] {
    TK_NUMBER  = 3'd0,
    TK_SYMBOL  = 3'd1,
    TK_ASSIGN  = 3'd2,
    TK_PLUS    = 3'd3,
    TK_MINUS   = 3'd4,
    TK_NEWLINE = 3'd5,
    TK_END     = 3'd6,
    TK_ERROR   = 3'd7
  } token_kind_e;

  typedef struct packed {
    token_kind_e kind;
    logic        is_error;
    logic [15:0] start_pos;
    logic [15:0] token_len;
    logic        last;
  } token_t;

  // Up to two tokens produced by one character
  typedef struct packed {
    logic   valid_a;
    token_t tok_a;
    logic   valid_b;
    token_t tok_b;
  } tok_pair_t;

endpackage

### hw/rtl/expression_token_lexer.sv
// Top level of the expression token lexer: scanner plus token queue.
// Depends on etl_pkg, etl_scan, etl_tok_fifo.
//
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+----------------------------------------
// in      | input     | in_valid_i/in_ready_o  | char_code_i
// out     | output    | out_valid_o/out_ready_i| token_kind_o, is_error_o, start_pos_o,
//         |           |                        | token_len_o, last_o
//
// One character is taken per cycle. The scanner classifies it and updates its
// mode/position registers in the same cycle and writes zero, one or two tokens
// into a four-entry token queue, which registers them. The queue drains one
// token per transfer, so a character that closes a run and yields its own
// token takes two output transfers. in_ready_o is high while the queue has
// room for two tokens; an output stall backs up into the queue and then stops
// the input. Reset clears the mode to idle, position and run start to zero,
// and empties the queue.
module expression_token_lexer import etl_pkg::*; #(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  token_kind_o,
  output logic        is_error_o,
  output logic [15:0] start_pos_o,
  output logic [15:0] token_len_o,
  output logic        last_o
);

  tok_pair_t pair;
  token_t    tok;
  logic      accept;

  // a transfer on the input channel
  assign accept = in_valid_i && in_ready_o;

  etl_scan #(
    .POS_WIDTH (POS_WIDTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (char_code_i),
    .pair_o      (pair)
  );

  etl_tok_fifo u_tok_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pair_i      (pair),
    .room2_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tok_o       (tok)
  );

  assign token_kind_o = tok.kind;
  assign is_error_o   = tok.is_error;
  assign start_pos_o  = tok.start_pos;
  assign token_len_o  = tok.token_len;
  assign last_o       = tok.last;

endmodule

### hw/rtl/etl_scan.sv
// Scanner: mode, position and run-start registers plus token generation.
// Depends on etl_pkg.
module etl_scan import etl_pkg::*; #(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_code_i,
  output tok_pair_t  pair_o
);

  localparam int unsigned EXT_W = (POS_WIDTH > 16) ? POS_WIDTH : 16;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_NUM  = 3'b010,
    MODE_SYM  = 3'b100
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [POS_WIDTH-1:0] start_q, start_d;
  logic [POS_WIDTH-1:0] pos_bump;

  logic is_dig, is_alpha, is_blank, is_nul, cont, in_run, own_present;
  token_t      close_tok, own_tok;
  token_kind_e own_kind;

  function automatic logic [15:0] sat16(input logic [POS_WIDTH-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return (e > EXT_W'(16'hFFFF)) ? 16'hFFFF : e[15:0];
  endfunction

  assign is_dig   = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign is_alpha = ((char_code_i >= CH_LOWER_A) && (char_code_i <= CH_LOWER_Z)) ||
                    ((char_code_i >= CH_UPPER_A) && (char_code_i <= CH_UPPER_Z));
  assign is_blank = (char_code_i == CH_SPACE) || (char_code_i == CH_TAB);
  assign is_nul   = (char_code_i == CH_NUL);
  assign pos_bump = (pos_q == {POS_WIDTH{1'b1}}) ? pos_q : pos_q + POS_WIDTH'(1);

  always_comb begin
    cont   = 1'b0;
    in_run = 1'b0;
    unique case (mode_q)
      MODE_NUM: begin
        in_run = 1'b1;
        cont   = is_dig;
      end
      MODE_SYM: begin
        in_run = 1'b1;
        cont   = is_alpha || is_dig || (char_code_i == CH_UNDERSCORE);
      end
      default: begin
        in_run = 1'b0;
        cont   = 1'b0;
      end
    endcase
  end

  assign own_present = !cont && !is_blank && !is_dig && !is_alpha;

  always_comb begin
    priority if (is_nul) begin
      own_kind = TK_END;
    end else if (char_code_i == CH_EQUALS) begin
      own_kind = TK_ASSIGN;
    end else if (char_code_i == CH_PLUS) begin
      own_kind = TK_PLUS;
    end else if (char_code_i == CH_MINUS) begin
      own_kind = TK_MINUS;
    end else if (char_code_i == CH_NEWLINE) begin
      own_kind = TK_NEWLINE;
    end else begin
      own_kind = TK_ERROR;
    end
  end

  always_comb begin
    close_tok.kind      = (mode_q == MODE_SYM) ? TK_SYMBOL : TK_NUMBER;
    close_tok.is_error  = 1'b0;
    close_tok.start_pos = sat16(start_q);
    close_tok.token_len = sat16(pos_q - start_q);
    close_tok.last      = !own_present;

    own_tok.kind      = own_kind;
    own_tok.is_error  = (own_kind == TK_ERROR);
    own_tok.start_pos = sat16(pos_q);
    own_tok.token_len = is_nul ? 16'd0 : 16'd1;
    own_tok.last      = 1'b1;
  end

  always_comb begin
    pair_o.valid_a = accept_i && ((in_run && !cont) || own_present);
    pair_o.tok_a   = (in_run && !cont) ? close_tok : own_tok;
    pair_o.valid_b = accept_i && in_run && !cont && own_present;
    pair_o.tok_b   = own_tok;
  end

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    if (accept_i) begin
      if (cont) begin
        pos_d = pos_bump;
      end else begin
        mode_d = MODE_IDLE;
        priority if (is_blank) begin
          pos_d = pos_bump;
        end else if (is_dig) begin
          mode_d  = MODE_NUM;
          start_d = pos_q;
          pos_d   = pos_bump;
        end else if (is_alpha) begin
          mode_d  = MODE_SYM;
          start_d = pos_q;
          pos_d   = pos_bump;
        end else if (is_nul) begin
          pos_d   = '0;
          start_d = '0;
        end else begin
          pos_d = pos_bump;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
    end
  end

  a_run_start_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q <= pos_q)
    else $error("run start beyond position");

  a_nul_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && is_nul) |=> (pos_q == '0 && mode_q == MODE_IDLE))
    else $error("end of source did not clear position");

  a_mode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mode_q))
    else $error("scan mode not one-hot");

endmodule

### hw/rtl/etl_tok_fifo.sv
// Token queue: takes up to two tokens per cycle, delivers one per transfer.
// Depends on etl_pkg.
module etl_tok_fifo import etl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tok_pair_t pair_i,
  output logic      room2_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output token_t    tok_o
);

  localparam int unsigned PTR_W = $clog2(TOKQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(TOKQ_DEPTH + 1);

  token_t             mem_q [TOKQ_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               pop;
  logic [1:0]         n_push;

  assign out_valid_o = (count_q != '0);
  assign tok_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room2_o     = (count_q <= CNT_W'(TOKQ_DEPTH - 2));
  assign n_push      = {1'b0, pair_i.valid_a} + {1'b0, pair_i.valid_b};
  assign count_d     = count_q + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (pair_i.valid_a) begin
      mem_q[wr_ptr_q] <= pair_i.tok_a;
    end
    if (pair_i.valid_b) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= pair_i.tok_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TOKQ_DEPTH))
    else $error("token queue overflow");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_i.valid_b |-> pair_i.valid_a)
    else $error("second token without first");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && n_push == 2'd0) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("queue count mismatch on drain");

endmodule
